@@ rtl/rvfpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfpd_pkg
// Shared types and constants for the RV32 fetch, predict and decode block.
// ----------------------------------------------------------------------------
package rvfpd_pkg;

    localparam int XLEN  = 32;
    localparam int OPC_W = 7;
    localparam int REG_W = 5;
    localparam int F3_W  = 3;
    localparam int F7_W  = 7;
    localparam int FMT_W = 3;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // item kind
    localparam logic OP_FETCH    = 1'b0;
    localparam logic OP_REDIRECT = 1'b1;

    // major opcodes
    localparam logic [OPC_W-1:0] OPC_OP     = 7'h33;
    localparam logic [OPC_W-1:0] OPC_OP_IMM = 7'h13;
    localparam logic [OPC_W-1:0] OPC_LOAD   = 7'h03;
    localparam logic [OPC_W-1:0] OPC_JALR   = 7'h67;
    localparam logic [OPC_W-1:0] OPC_STORE  = 7'h23;
    localparam logic [OPC_W-1:0] OPC_BRANCH = 7'h63;
    localparam logic [OPC_W-1:0] OPC_AUIPC  = 7'h17;
    localparam logic [OPC_W-1:0] OPC_LUI    = 7'h37;
    localparam logic [OPC_W-1:0] OPC_JAL    = 7'h6f;

    typedef enum logic [FMT_W-1:0] {
        FMT_R   = 3'd0,
        FMT_I   = 3'd1,
        FMT_S   = 3'd2,
        FMT_B   = 3'd3,
        FMT_U   = 3'd4,
        FMT_J   = 3'd5,
        FMT_NOP = 3'd6
    } fmt_t;

    typedef struct packed {
        logic [XLEN-1:0]         next_pc;
        fmt_t                    format;
        logic [OPC_W-1:0]        opcode;
        logic [REG_W-1:0]        rd;
        logic [REG_W-1:0]        rs1;
        logic [REG_W-1:0]        rs2;
        logic [F3_W-1:0]         funct3;
        logic [F7_W-1:0]         funct7;
        logic signed [XLEN-1:0]  imm;
    } dec_t;

endpackage

@@ rtl/rvfpd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfpd_if
// Valid/ready channels: fetch request word in, decoded word out.
// ----------------------------------------------------------------------------
interface rvfpd_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] redirect_pc;
    logic [31:0] instruction_word;
    logic        predict_taken;

    modport source (output valid, op, redirect_pc, instruction_word, predict_taken,
                    input ready);
    modport sink   (input valid, op, redirect_pc, instruction_word, predict_taken,
                    output ready);
endinterface

interface rvfpd_rsp_if;
    logic               valid;
    logic               ready;
    logic [31:0]        fetch_pc;
    logic [31:0]        next_pc;
    logic [2:0]         format;
    logic [6:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_one;
    logic [4:0]         src_reg_two;
    logic [2:0]         funct_three;
    logic [6:0]         funct_seven;
    logic signed [31:0] immediate;

    modport source (output valid, fetch_pc, next_pc, format, opcode, dest_reg,
                    src_reg_one, src_reg_two, funct_three, funct_seven, immediate,
                    input ready);
    modport sink   (input valid, fetch_pc, next_pc, format, opcode, dest_reg,
                    src_reg_one, src_reg_two, funct_three, funct_seven, immediate,
                    output ready);
endinterface

@@ rtl/rvfpd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvfpd_decode
// Opcode classification, field and immediate extraction, next-PC prediction.
// ----------------------------------------------------------------------------
module rvfpd_decode (
    input  logic [31:0]    pc,
    input  logic [31:0]    word,
    input  logic           taken,
    output rvfpd_pkg::dec_t dec
);
    import rvfpd_pkg::*;

    logic [OPC_W-1:0]       opc;
    logic signed [XLEN-1:0] imm_i;
    logic signed [XLEN-1:0] imm_s;
    logic signed [XLEN-1:0] imm_b;
    logic signed [XLEN-1:0] imm_u;
    logic signed [XLEN-1:0] imm_j;
    logic [XLEN-1:0]        target;
    logic [XLEN-1:0]        seq_pc;

    assign opc   = word[OPC_W-1:0];
    assign imm_i = {{20{word[31]}}, word[31:20]};
    assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    assign imm_u = {word[31:12], 12'b0};
    assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

    always_comb
    begin
        dec         = '0;
        dec.opcode  = opc;
        dec.format  = FMT_NOP;
        unique case (opc) inside
            OPC_OP:
            begin
                dec.format = FMT_R;
                dec.rd     = word[11:7];
                dec.funct3 = word[14:12];
                dec.rs1    = word[19:15];
                dec.rs2    = word[24:20];
                dec.funct7 = word[31:25];
            end
            OPC_OP_IMM, OPC_LOAD, OPC_JALR:
            begin
                dec.format = FMT_I;
                dec.rd     = word[11:7];
                dec.funct3 = word[14:12];
                dec.rs1    = word[19:15];
                dec.imm    = imm_i;
            end
            OPC_STORE:
            begin
                dec.format = FMT_S;
                dec.funct3 = word[14:12];
                dec.rs1    = word[19:15];
                dec.rs2    = word[24:20];
                dec.imm    = imm_s;
            end
            OPC_BRANCH:
            begin
                dec.format = FMT_B;
                dec.funct3 = word[14:12];
                dec.rs1    = word[19:15];
                dec.rs2    = word[24:20];
                dec.imm    = imm_b;
            end
            OPC_AUIPC, OPC_LUI:
            begin
                dec.format = FMT_U;
                dec.rd     = word[11:7];
                dec.imm    = imm_u;
            end
            OPC_JAL:
            begin
                dec.format = FMT_J;
                dec.rd     = word[11:7];
                dec.imm    = imm_j;
            end
            default:
            begin
                dec.format = FMT_NOP;
            end
        endcase

        target      = pc + $unsigned(dec.imm);
        seq_pc      = pc + PC_STEP;
        dec.next_pc = seq_pc;
        if ((dec.format == FMT_B && taken) || dec.format == FMT_J)
        begin
            dec.next_pc = target;
        end
    end

endmodule

@@ rtl/riscv_fetch_predict_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_fetch_predict_decode
// RV32 fetch stage: holds the fetch address, decodes words, predicts next PC.
// ----------------------------------------------------------------------------
// fetch_req carries one word per handshake: op = fetch (instruction word at
// the current fetch address plus the predictor's taken bit) or op = redirect
// (load a new fetch address, no decoded word comes out).
// decode_rsp returns, per fetch word, the fetch address, the predicted next
// address, the format and the decoded register, funct and immediate fields.
// A fetch word passes the input and result registers. Throughput: one word
// per cycle while decode_rsp does not stall; the loop that sets it is the
// address register through one 32-bit add and a select back into itself.
// The input register and the result register are separate, so a new word is
// taken while a finished word waits on decode_rsp. When decode_rsp stalls, the
// held input word waits and fetch_req.ready drops once the input register is
// full; a redirect word still drains past a stalled output.
// Reset clears the fetch address to zero and empties both registers.
// ----------------------------------------------------------------------------
module riscv_fetch_predict_decode (
    input  logic          clk,
    input  logic          rst_n,
    rvfpd_req_if.sink     fetch_req,
    rvfpd_rsp_if.source   decode_rsp
);
    import rvfpd_pkg::*;

    logic            in_valid_reg;
    logic            in_valid_next;
    logic            in_op_reg;
    logic [XLEN-1:0] in_redirect_reg;
    logic [XLEN-1:0] in_word_reg;
    logic            in_taken_reg;

    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] pc_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [XLEN-1:0] out_pc_reg;
    dec_t            out_dec_reg;

    dec_t            dec;
    logic            advance;
    logic            adv_fetch;
    logic            take_in;

    rvfpd_decode u_decode (
        .pc    (pc_reg),
        .word  (in_word_reg),
        .taken (in_taken_reg),
        .dec   (dec)
    );

    assign advance   = in_valid_reg &&
                       (in_op_reg == OP_REDIRECT || !out_valid_reg || decode_rsp.ready);
    assign adv_fetch = advance && in_op_reg == OP_FETCH;
    assign take_in   = fetch_req.valid && fetch_req.ready;

    assign fetch_req.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = adv_fetch || (out_valid_reg && !decode_rsp.ready);
        pc_next        = pc_reg;
        if (advance)
        begin
            pc_next = (in_op_reg == OP_REDIRECT) ? in_redirect_reg : dec.next_pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg       <= fetch_req.op;
            in_redirect_reg <= fetch_req.redirect_pc;
            in_word_reg     <= fetch_req.instruction_word;
            in_taken_reg    <= fetch_req.predict_taken;
        end
        if (adv_fetch)
        begin
            out_pc_reg  <= pc_reg;
            out_dec_reg <= dec;
        end
    end

    assign decode_rsp.valid       = out_valid_reg;
    assign decode_rsp.fetch_pc    = out_pc_reg;
    assign decode_rsp.next_pc     = out_dec_reg.next_pc;
    assign decode_rsp.format      = out_dec_reg.format;
    assign decode_rsp.opcode      = out_dec_reg.opcode;
    assign decode_rsp.dest_reg    = out_dec_reg.rd;
    assign decode_rsp.src_reg_one = out_dec_reg.rs1;
    assign decode_rsp.src_reg_two = out_dec_reg.rs2;
    assign decode_rsp.funct_three = out_dec_reg.funct3;
    assign decode_rsp.funct_seven = out_dec_reg.funct7;
    assign decode_rsp.immediate   = out_dec_reg.imm;

    // fetch address follows the word just decoded
    a_pc_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv_fetch |=> (pc_reg == decode_rsp.next_pc && decode_rsp.valid))
        else $error("fetch address does not match predicted next pc");

    a_redirect_load: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_REDIRECT) |=> pc_reg == $past(in_redirect_reg))
        else $error("redirect did not load fetch address");

    a_redirect_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_REDIRECT && !out_valid_reg) |=> !decode_rsp.valid)
        else $error("redirect produced a decoded word");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |-> advance)
        else $error("held word stalled with empty output register");

    a_pc_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pc_reg))
        else $error("fetch address moved without an advancing word");

endmodule
